// ===== hw/rtl/ups_pkg.sv =====
// Shared types and constants for the UDP port steering classifier.
// Used by ups_parser, ups_fifo, ups_verdict and the top level.
package ups_pkg;

  localparam int FRAME_BYTE_W = 8;
  localparam int QUEUE_W      = 6;
  localparam int PORT_W       = 16;
  localparam int MASK_W       = 64;
  localparam int POS_W        = 7;
  localparam int IHL_BYTES_W  = 6;
  localparam int CFG_INDEX_W  = 1;

  localparam int QUEUE_DEPTH  = 4;
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOCKET_MASK = 1'b0,
    REG_MATCH_PORT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    PH_ETH  = 5'b00001,
    PH_TAG  = 5'b00010,
    PH_IP   = 5'b00100,
    PH_UDP  = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  localparam logic [POS_W-1:0]  POS_MAX         = 7'd127;
  localparam logic [POS_W-1:0]  ETH_TYPE_POS    = 7'd13;
  localparam logic [POS_W-1:0]  TAG_TYPE_POS    = 7'd17;
  localparam logic [POS_W-1:0]  IP_OFF_UNTAGGED = 7'd14;
  localparam logic [POS_W-1:0]  IP_OFF_TAGGED   = 7'd18;
  localparam logic [7:0]        IP_PROTO_OFF    = 8'd9;
  localparam logic [7:0]        UDP_DPORT_LAST  = 8'd3;
  localparam logic [7:0]        UDP_HDR_LAST    = 8'd7;
  localparam logic [IHL_BYTES_W-1:0] IHL_MIN_BYTES = 6'd20;

  localparam logic [15:0] ETYPE_MIN  = 16'h0600;
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_QINQ = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP = 8'd17;

  localparam logic [PORT_W-1:0] MATCH_PORT_RESET = 16'd4433;

  // Per-frame outcome of the parser, queued for the mask lookup.
  typedef struct packed {
    logic               ok;
    logic [QUEUE_W-1:0] queue;
  } verdict_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/udp_port_packet_steering.sv =====
// Top level of the UDP port steering classifier: configuration registers,
// parser front end, verdict queue and mask lookup back end. Depends on ups_pkg.
//
// Frame bytes are taken one per cycle on the slave stream (tlast marks the
// final byte, tuser carries the receive queue). The parser checks Ethernet,
// one optional 802.1Q/802.1ad tag, IPv4 with IHL >= 5, UDP and the destination
// port, and queues one verdict on the final byte; the back end looks up the
// queue's socket bit as that verdict leaves the queue and registers the result.
// A four-entry verdict queue decouples the sides, so the input stalls only
// while that queue is full, i.e. four verdicts wait behind a result the master
// stream has not yet taken. Write configuration only when no frame is in flight.
module udp_port_packet_steering #(
  parameter int QUEUE_COUNT = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] frame_byte
  input  logic                               s_axis_tlast,
  input  logic [ups_pkg::QUEUE_W-1:0]        s_axis_tuser,  // [5:0] rx_queue
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [5:0] target_queue
  output logic [0:0]                         m_axis_tuser,  // [0] redirect
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ups_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ups_pkg::MASK_W-1:0]         cfg_data
);

  logic [QUEUE_COUNT-1:0]          socket_mask;
  logic [ups_pkg::MASK_W-1:0]      mask_ext;
  logic [ups_pkg::PORT_W-1:0]      match_port;

  logic                            push;
  logic                            pop;
  ups_pkg::verdict_t               push_data;
  ups_pkg::verdict_t               head;
  ups_pkg::fifo_stat_t             fifo_stat;
  logic [ups_pkg::CNT_W-1:0]       fifo_count;
  logic                            redirect;
  logic [ups_pkg::QUEUE_W-1:0]     target_queue;

  assign cfg_ready = 1'b1;
  // queues at or beyond QUEUE_COUNT read as unbound
  assign mask_ext  = ups_pkg::MASK_W'(socket_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      socket_mask <= '0;
      match_port  <= ups_pkg::MATCH_PORT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ups_pkg::cfg_reg_t'(cfg_index))
        ups_pkg::REG_SOCKET_MASK: socket_mask <= cfg_data[QUEUE_COUNT-1:0];
        ups_pkg::REG_MATCH_PORT:  match_port  <= cfg_data[ups_pkg::PORT_W-1:0];
        default:                  match_port  <= match_port;
      endcase
    end
  end

  ups_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .in_queue   (s_axis_tuser),
    .match_port (match_port),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_data  (push_data)
  );

  ups_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat),
    .count     (fifo_count)
  );

  ups_verdict u_verdict (
    .clk          (clk),
    .rst          (rst),
    .fifo_stat    (fifo_stat),
    .head         (head),
    .pop          (pop),
    .socket_mask  (mask_ext),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .redirect     (redirect),
    .target_queue (target_queue)
  );

  assign m_axis_tdata = {2'b00, target_queue};
  assign m_axis_tuser = redirect;

`ifndef SYNTH
  // a frame's final byte must leave a verdict in the queue or the result stage
  a_verdict_held: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast
      |=> (fifo_count != '0) || m_axis_tvalid)
    else $error("final byte accepted but no verdict held");

  // a pass result never names a queue
  a_pass_zero_queue: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
    else $error("pass result carries a nonzero queue");

  // input must stall whenever the verdict queue is full
  a_stall_on_full: assert property (@(posedge clk) disable iff (rst)
    fifo_stat.full |-> !s_axis_tready)
    else $error("input accepted while verdict queue full");
`endif

endmodule

// ===== hw/rtl/ups_parser.sv =====
// Front end: byte-serial Ethernet/VLAN/IPv4/UDP header parser.
// Pushes one verdict per frame into the queue; depends on ups_pkg.
module ups_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ups_pkg::FRAME_BYTE_W-1:0]  in_byte,
  input  logic                              in_last,
  input  logic [ups_pkg::QUEUE_W-1:0]       in_queue,
  input  logic [ups_pkg::PORT_W-1:0]        match_port,
  input  ups_pkg::fifo_stat_t               fifo_stat,
  output logic                              push,
  output ups_pkg::verdict_t                 push_data
);

  logic [ups_pkg::POS_W-1:0]       pos;
  ups_pkg::phase_t                 phase, phase_next;
  logic [15:0]                     type_shift, type_shift_next;
  logic [ups_pkg::IHL_BYTES_W-1:0] ihl_bytes, ihl_bytes_next;
  logic [ups_pkg::POS_W-1:0]       hdr_off, hdr_off_next;
  logic                            matched, matched_next;
  logic                            complete, complete_next;

  logic                            accept;
  logic [7:0]                      pos8, off8;
  logic [ups_pkg::IHL_BYTES_W-1:0] ihl_in;

  assign in_ready = !fifo_stat.full;
  assign accept   = in_valid && in_ready;

  assign type_shift_next = {type_shift[7:0], in_byte};
  assign pos8   = {1'b0, pos};
  assign off8   = {1'b0, hdr_off};
  assign ihl_in = {in_byte[3:0], 2'b00};

  always_comb begin
    phase_next     = phase;
    ihl_bytes_next = ihl_bytes;
    hdr_off_next   = hdr_off;
    matched_next   = matched;
    complete_next  = complete;
    unique case (phase)
      ups_pkg::PH_ETH: begin
        if (pos == ups_pkg::ETH_TYPE_POS) begin
          priority if (type_shift_next < ups_pkg::ETYPE_MIN) begin
            matched_next = 1'b0;
            phase_next   = ups_pkg::PH_DONE;
          end else if (type_shift_next == ups_pkg::ETYPE_VLAN ||
                       type_shift_next == ups_pkg::ETYPE_QINQ) begin
            phase_next = ups_pkg::PH_TAG;
          end else if (type_shift_next == ups_pkg::ETYPE_IPV4) begin
            hdr_off_next = ups_pkg::IP_OFF_UNTAGGED;
            phase_next   = ups_pkg::PH_IP;
          end else begin
            matched_next = 1'b0;
            phase_next   = ups_pkg::PH_DONE;
          end
        end
      end
      ups_pkg::PH_TAG: begin
        if (pos == ups_pkg::TAG_TYPE_POS) begin
          if (type_shift_next == ups_pkg::ETYPE_IPV4) begin
            hdr_off_next = ups_pkg::IP_OFF_TAGGED;
            phase_next   = ups_pkg::PH_IP;
          end else begin
            matched_next = 1'b0;
            phase_next   = ups_pkg::PH_DONE;
          end
        end
      end
      ups_pkg::PH_IP: begin
        if (pos8 == off8) begin
          ihl_bytes_next = ihl_in;
          if (ihl_in < ups_pkg::IHL_MIN_BYTES) begin
            matched_next = 1'b0;
            phase_next   = ups_pkg::PH_DONE;
          end
        end else if (pos8 == off8 + ups_pkg::IP_PROTO_OFF) begin
          if (in_byte == ups_pkg::IP_PROTO_UDP) begin
            // advance the offset to the start of the UDP header
            hdr_off_next = hdr_off + {1'b0, ihl_bytes};
            phase_next   = ups_pkg::PH_UDP;
          end else begin
            matched_next = 1'b0;
            phase_next   = ups_pkg::PH_DONE;
          end
        end
      end
      ups_pkg::PH_UDP: begin
        if (pos8 == off8 + ups_pkg::UDP_DPORT_LAST) begin
          if (type_shift_next != match_port) begin
            matched_next = 1'b0;
            phase_next   = ups_pkg::PH_DONE;
          end
        end else if (pos8 == off8 + ups_pkg::UDP_HDR_LAST) begin
          complete_next = 1'b1;
          phase_next    = ups_pkg::PH_DONE;
        end
      end
      ups_pkg::PH_DONE: begin
        phase_next = ups_pkg::PH_DONE;
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  assign push            = accept && in_last;
  assign push_data.ok    = matched_next && complete_next;
  assign push_data.queue = in_queue;

  always_ff @(posedge clk) begin
    if (rst || (accept && in_last)) begin
      pos        <= '0;
      phase      <= ups_pkg::PH_ETH;
      type_shift <= '0;
      ihl_bytes  <= '0;
      hdr_off    <= '0;
      matched    <= 1'b1;
      complete   <= 1'b0;
    end else if (accept) begin
      if (pos != ups_pkg::POS_MAX) begin
        pos <= pos + 7'd1;
      end
      phase      <= phase_next;
      type_shift <= type_shift_next;
      ihl_bytes  <= ihl_bytes_next;
      hdr_off    <= hdr_off_next;
      matched    <= matched_next;
      complete   <= complete_next;
    end
  end

endmodule

// ===== hw/rtl/ups_fifo.sv =====
// Short verdict queue between the parser and the mask lookup.
// Depth from ups_pkg::QUEUE_DEPTH; depends on ups_pkg.
module ups_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ups_pkg::verdict_t   push_data,
  input  logic                pop,
  output ups_pkg::verdict_t   head,
  output ups_pkg::fifo_stat_t stat,
  output logic [ups_pkg::CNT_W-1:0] count
);

  ups_pkg::verdict_t         mem [ups_pkg::QUEUE_DEPTH];
  logic [ups_pkg::PTR_W-1:0] wr_ptr;
  logic [ups_pkg::PTR_W-1:0] rd_ptr;
  logic                      do_push;
  logic                      do_pop;

  assign stat.full  = (count == ups_pkg::CNT_W'(ups_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ups_verdict.sv =====
// Back end: socket mask lookup and registered result stage.
// Takes queued verdicts from ups_fifo; depends on ups_pkg.
module ups_verdict (
  input  logic                         clk,
  input  logic                         rst,
  input  ups_pkg::fifo_stat_t          fifo_stat,
  input  ups_pkg::verdict_t            head,
  output logic                         pop,
  input  logic [ups_pkg::MASK_W-1:0]   socket_mask,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         redirect,
  output logic [ups_pkg::QUEUE_W-1:0]  target_queue
);

  logic bound;

  assign bound = socket_mask[head.queue];
  // refill the result register whenever it is empty or being taken
  assign pop   = !fifo_stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      redirect     <= head.ok && bound;
      target_queue <= (head.ok && bound) ? head.queue : '0;
    end
  end

endmodule
